// ----- src/fnvi_pkg.sv -----
// Shared types, constants and node tables for the nodal value interpolator.
// No dependencies; every other file of the block refers to this package.
package fnvi_pkg;

    // Field and datapath sizes
    localparam int VTX_W         = 32;
    localparam int N_VTX         = 8;
    localparam int WORD_W        = 36;   // holds 11 x 2^31 with sign
    localparam int NDIG          = WORD_W / 4;
    localparam int DIV_STAGES    = 3;
    localparam int DIG_PER_STAGE = NDIG / DIV_STAGES;
    localparam int MAX_COPY      = 8;

    // Input item
    typedef struct packed {
        logic [3:0]              elem_kind;
        logic [1:0]              total_order;
        logic [3:0]              copy_count;
        logic signed [VTX_W-1:0] vertex_0;
        logic signed [VTX_W-1:0] vertex_1;
        logic signed [VTX_W-1:0] vertex_2;
        logic signed [VTX_W-1:0] vertex_3;
        logic signed [VTX_W-1:0] vertex_4;
        logic signed [VTX_W-1:0] vertex_5;
        logic signed [VTX_W-1:0] vertex_6;
        logic signed [VTX_W-1:0] vertex_7;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [4:0]              node_index;
        logic signed [VTX_W-1:0] node_value;
        logic                    last_node;
    } t_out_item;

    // Node layout of one item
    typedef enum logic [3:0] {
        SCH_EDGE3,
        SCH_EDGE4,
        SCH_TRI6,
        SCH_QUAD8,
        SCH_QUAD9,
        SCH_TET10,
        SCH_HEX20,
        SCH_HEX27,
        SCH_PRISM15,
        SCH_PRISM18,
        SCH_EDGE4_P2,
        SCH_COPY
    } t_scheme;

    // Operation for one node
    typedef enum logic [2:0] {
        OP_COPY,
        OP_HALF,
        OP_QUART,
        OP_EIGHTH,
        OP_THIRD,
        OP_NINTH
    } t_op;

    typedef enum logic [1:0] {
        DIV_NONE,
        DIV_3,
        DIV_9
    } t_dsel;

    typedef struct packed {
        t_op        op;
        logic [2:0] a;
        logic [2:0] b;
        logic [2:0] c;
        logic [2:0] d;
    } t_node_op;

    // Sequencer to node arithmetic
    typedef struct packed {
        logic                                valid;
        t_scheme                             scheme;
        logic [4:0]                          k;
        logic                                last;
        logic [N_VTX-1:0][VTX_W-1:0]         vtx;
    } t_node_req;

    // Word travelling through the divider stages
    typedef struct packed {
        logic              valid;
        logic [4:0]        idx;
        logic              last;
        t_dsel             dsel;
        logic              neg;
        logic [3:0]        rem;
        logic [WORD_W-1:0] word;
    } t_dpipe;

    // Scheme from kind and order
    function automatic t_scheme decode_scheme(input logic [3:0] kind,
                                              input logic [1:0] order);
        t_scheme s;
        s = SCH_COPY;
        if (order == 2'd1) begin
            case (kind)
                4'd0:    s = SCH_EDGE3;
                4'd1:    s = SCH_EDGE4;
                4'd2:    s = SCH_TRI6;
                4'd3:    s = SCH_QUAD8;
                4'd4:    s = SCH_QUAD9;
                4'd5:    s = SCH_TET10;
                4'd6:    s = SCH_HEX20;
                4'd7:    s = SCH_HEX27;
                4'd8:    s = SCH_PRISM15;
                4'd9:    s = SCH_PRISM18;
                default: s = SCH_COPY;
            endcase
        end else if (order == 2'd2 && kind == 4'd1) begin
            s = SCH_EDGE4_P2;
        end
        return s;
    endfunction

    // Number of nodes the scheme emits
    function automatic logic [4:0] node_total(input t_scheme s, input logic [3:0] cnt);
        logic [4:0] n;
        case (s)
            SCH_EDGE3:    n = 5'd3;
            SCH_EDGE4:    n = 5'd4;
            SCH_TRI6:     n = 5'd6;
            SCH_QUAD8:    n = 5'd8;
            SCH_QUAD9:    n = 5'd9;
            SCH_TET10:    n = 5'd10;
            SCH_HEX20:    n = 5'd20;
            SCH_HEX27:    n = 5'd27;
            SCH_PRISM15:  n = 5'd15;
            SCH_PRISM18:  n = 5'd18;
            SCH_EDGE4_P2: n = 5'd4;
            default:      n = (cnt > 4'(MAX_COPY)) ? 5'(MAX_COPY) : {1'b0, cnt};
        endcase
        return n;
    endfunction

    // Edge vertex pairs, {a, b}
    function automatic logic [5:0] tri_pair(input logic [3:0] i);
        case (i)
            4'd0:    return {3'd0, 3'd1};
            4'd1:    return {3'd1, 3'd2};
            default: return {3'd2, 3'd0};
        endcase
    endfunction

    function automatic logic [5:0] quad_pair(input logic [3:0] i);
        case (i)
            4'd0:    return {3'd0, 3'd1};
            4'd1:    return {3'd1, 3'd2};
            4'd2:    return {3'd2, 3'd3};
            default: return {3'd3, 3'd0};
        endcase
    endfunction

    function automatic logic [5:0] tet_pair(input logic [3:0] i);
        case (i)
            4'd0:    return {3'd0, 3'd1};
            4'd1:    return {3'd1, 3'd2};
            4'd2:    return {3'd2, 3'd0};
            4'd3:    return {3'd3, 3'd0};
            4'd4:    return {3'd3, 3'd1};
            default: return {3'd3, 3'd2};
        endcase
    endfunction

    function automatic logic [5:0] hex_pair(input logic [3:0] i);
        case (i)
            4'd0:    return {3'd0, 3'd1};
            4'd1:    return {3'd1, 3'd2};
            4'd2:    return {3'd2, 3'd3};
            4'd3:    return {3'd3, 3'd0};
            4'd4:    return {3'd0, 3'd4};
            4'd5:    return {3'd1, 3'd5};
            4'd6:    return {3'd2, 3'd6};
            4'd7:    return {3'd3, 3'd7};
            4'd8:    return {3'd4, 3'd5};
            4'd9:    return {3'd5, 3'd6};
            4'd10:   return {3'd6, 3'd7};
            default: return {3'd4, 3'd7};
        endcase
    endfunction

    function automatic logic [5:0] prism_pair(input logic [3:0] i);
        case (i)
            4'd0:    return {3'd0, 3'd1};
            4'd1:    return {3'd1, 3'd2};
            4'd2:    return {3'd0, 3'd2};
            4'd3:    return {3'd0, 3'd3};
            4'd4:    return {3'd1, 3'd4};
            4'd5:    return {3'd2, 3'd5};
            4'd6:    return {3'd3, 3'd4};
            4'd7:    return {3'd4, 3'd5};
            default: return {3'd3, 3'd5};
        endcase
    endfunction

    // Face vertex quadruples, {a, b, c, d}
    function automatic logic [11:0] hex_face(input logic [3:0] i);
        case (i)
            4'd0:    return {3'd0, 3'd1, 3'd2, 3'd3};
            4'd1:    return {3'd0, 3'd1, 3'd4, 3'd5};
            4'd2:    return {3'd1, 3'd2, 3'd5, 3'd6};
            4'd3:    return {3'd2, 3'd3, 3'd6, 3'd7};
            4'd4:    return {3'd3, 3'd0, 3'd7, 3'd4};
            default: return {3'd4, 3'd5, 3'd6, 3'd7};
        endcase
    endfunction

    function automatic logic [11:0] prism_face(input logic [3:0] i);
        case (i)
            4'd0:    return {3'd0, 3'd1, 3'd4, 3'd3};
            4'd1:    return {3'd1, 3'd2, 3'd5, 3'd4};
            default: return {3'd2, 3'd0, 3'd3, 3'd5};
        endcase
    endfunction

    // Operation and operands for node k of a scheme
    function automatic t_node_op node_op(input t_scheme s, input logic [4:0] k);
        t_node_op   r;
        logic [4:0] o4;
        logic [4:0] o6;
        logic [4:0] o8;
        logic [4:0] o15;
        logic [4:0] o20;
        r   = '{op: OP_COPY, a: k[2:0], b: 3'd0, c: 3'd0, d: 3'd0};
        o4  = k - 5'd4;
        o6  = k - 5'd6;
        o8  = k - 5'd8;
        o15 = k - 5'd15;
        o20 = k - 5'd20;
        case (s)
            SCH_EDGE3: begin
                if (k == 5'd2) begin
                    r.op = OP_HALF; r.a = 3'd0; r.b = 3'd1;
                end
            end
            SCH_EDGE4: begin
                if (k == 5'd2) begin
                    r.op = OP_THIRD; r.a = 3'd0; r.b = 3'd1;
                end else if (k == 5'd3) begin
                    r.op = OP_THIRD; r.a = 3'd1; r.b = 3'd0;
                end
            end
            SCH_EDGE4_P2: begin
                if (k == 5'd2) begin
                    r.op = OP_NINTH; r.a = 3'd0; r.b = 3'd1; r.c = 3'd2;
                end else if (k == 5'd3) begin
                    r.op = OP_NINTH; r.a = 3'd1; r.b = 3'd0; r.c = 3'd2;
                end
            end
            SCH_TRI6: begin
                if (k >= 5'd3) begin
                    r.op = OP_HALF;
                    {r.a, r.b} = tri_pair(4'(k - 5'd3));
                end
            end
            SCH_QUAD8, SCH_QUAD9: begin
                if (k >= 5'd8) begin
                    r.op = OP_QUART; r.a = 3'd0; r.b = 3'd1; r.c = 3'd2; r.d = 3'd3;
                end else if (k >= 5'd4) begin
                    r.op = OP_HALF;
                    {r.a, r.b} = quad_pair(o4[3:0]);
                end
            end
            SCH_TET10: begin
                if (k >= 5'd4) begin
                    r.op = OP_HALF;
                    {r.a, r.b} = tet_pair(o4[3:0]);
                end
            end
            SCH_HEX20, SCH_HEX27: begin
                if (k >= 5'd26) begin
                    r.op = OP_EIGHTH;
                end else if (k >= 5'd20) begin
                    r.op = OP_QUART;
                    {r.a, r.b, r.c, r.d} = hex_face(o20[3:0]);
                end else if (k >= 5'd8) begin
                    r.op = OP_HALF;
                    {r.a, r.b} = hex_pair(o8[3:0]);
                end
            end
            SCH_PRISM15, SCH_PRISM18: begin
                if (k >= 5'd15) begin
                    r.op = OP_QUART;
                    {r.a, r.b, r.c, r.d} = prism_face(o15[3:0]);
                end else if (k >= 5'd6) begin
                    r.op = OP_HALF;
                    {r.a, r.b} = prism_pair(o6[3:0]);
                end
            end
            default: begin
                r.op = OP_COPY;
            end
        endcase
        return r;
    endfunction

    // One decimal-free long division step: v = {rem, digit}, returns {q, rem}
    function automatic logic [7:0] div_digit(input logic [7:0] v, input logic [3:0] d);
        logic [3:0] q;
        logic [7:0] prod;
        logic [7:0] r;
        q = 4'd0;
        for (int j = 1; j < 16; j++) begin
            if (v >= 8'(j) * {4'd0, d}) q = 4'(j);
        end
        prod = {4'd0, q} * {4'd0, d};
        r    = v - prod;
        return {q, r[3:0]};
    endfunction

endpackage

// ----- src/fnvi_seq.sv -----
// Item buffering and node sequencer: holds the item being emitted and one waiting item.
// Depends on fnvi_pkg.
module fnvi_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  fnvi_pkg::t_in_item   i_item,
    output fnvi_pkg::t_node_req  o_req
);

    logic                                                  r_cur_valid, n_cur_valid;
    logic                                                  r_pend_valid, n_pend_valid;
    logic [fnvi_pkg::N_VTX-1:0][fnvi_pkg::VTX_W-1:0]       r_cur_vtx, n_cur_vtx;
    logic [fnvi_pkg::N_VTX-1:0][fnvi_pkg::VTX_W-1:0]       r_pend_vtx, n_pend_vtx;
    fnvi_pkg::t_scheme                                     r_cur_sch, n_cur_sch;
    fnvi_pkg::t_scheme                                     r_pend_sch, n_pend_sch;
    logic [4:0]                                            r_cur_total, n_cur_total;
    logic [4:0]                                            r_pend_total, n_pend_total;
    logic [4:0]                                            r_k, n_k;

    logic                                                  accept;
    logic                                                  cur_last;
    logic                                                  cur_free;
    fnvi_pkg::t_scheme                                     in_sch;
    logic [4:0]                                            in_total;
    logic [fnvi_pkg::N_VTX-1:0][fnvi_pkg::VTX_W-1:0]       in_vtx;

    // Decode the offered item
    always_comb begin
        in_sch   = fnvi_pkg::decode_scheme(i_item.elem_kind, i_item.total_order);
        in_total = fnvi_pkg::node_total(in_sch, i_item.copy_count);
        in_vtx   = {i_item.vertex_7, i_item.vertex_6, i_item.vertex_5, i_item.vertex_4,
                    i_item.vertex_3, i_item.vertex_2, i_item.vertex_1, i_item.vertex_0};
    end

    assign accept   = start && !r_pend_valid;
    assign cur_last = r_cur_valid && (r_k == r_cur_total - 5'd1);
    assign cur_free = !r_cur_valid || cur_last;
    assign busy     = r_pend_valid;

    // Next state: an item with no nodes is taken and dropped
    always_comb begin
        n_cur_valid  = r_cur_valid;
        n_pend_valid = r_pend_valid;
        n_cur_vtx    = r_cur_vtx;
        n_pend_vtx   = r_pend_vtx;
        n_cur_sch    = r_cur_sch;
        n_pend_sch   = r_pend_sch;
        n_cur_total  = r_cur_total;
        n_pend_total = r_pend_total;
        n_k          = r_k;
        if (r_cur_valid && !cur_last) n_k = r_k + 5'd1;
        if (cur_free) begin
            n_k = 5'd0;
            if (r_pend_valid) begin
                n_cur_valid  = 1'b1;
                n_cur_vtx    = r_pend_vtx;
                n_cur_sch    = r_pend_sch;
                n_cur_total  = r_pend_total;
                n_pend_valid = 1'b0;
            end else if (accept && in_total != 5'd0) begin
                n_cur_valid  = 1'b1;
                n_cur_vtx    = in_vtx;
                n_cur_sch    = in_sch;
                n_cur_total  = in_total;
            end else begin
                n_cur_valid  = 1'b0;
            end
        end else if (accept && in_total != 5'd0) begin
            n_pend_valid = 1'b1;
            n_pend_vtx   = in_vtx;
            n_pend_sch   = in_sch;
            n_pend_total = in_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_k          <= 5'd0;
        end else begin
            r_cur_valid  <= n_cur_valid;
            r_pend_valid <= n_pend_valid;
            r_k          <= n_k;
        end
        r_cur_vtx    <= n_cur_vtx;
        r_pend_vtx   <= n_pend_vtx;
        r_cur_sch    <= n_cur_sch;
        r_pend_sch   <= n_pend_sch;
        r_cur_total  <= n_cur_total;
        r_pend_total <= n_pend_total;
    end

    // Node request for the arithmetic stage
    always_comb begin
        o_req.valid  = r_cur_valid;
        o_req.scheme = r_cur_sch;
        o_req.k      = r_k;
        o_req.last   = cur_last;
        o_req.vtx    = r_cur_vtx;
    end

endmodule

// ----- src/fnvi_node_calc.sv -----
// Node arithmetic stage: picks the operands of one node and forms its sum, registered.
// Depends on fnvi_pkg.
module fnvi_node_calc #(
    parameter int EFF_W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fnvi_pkg::t_node_req i_req,
    output fnvi_pkg::t_dpipe    o_stage
);

    localparam int WW = fnvi_pkg::WORD_W;

    logic signed [WW-1:0] v [fnvi_pkg::N_VTX];
    logic signed [WW-1:0] va, vb, vc, vd;
    logic signed [WW-1:0] sum;
    logic signed [WW-1:0] all8;
    fnvi_pkg::t_node_op   nop;
    fnvi_pkg::t_dpipe     n_stage;
    fnvi_pkg::t_dpipe     r_stage;

    // Sign-extend each vertex from its effective width
    always_comb begin
        for (int i = 0; i < fnvi_pkg::N_VTX; i++) begin
            v[i] = $signed({{(WW - EFF_W){i_req.vtx[i][EFF_W-1]}}, i_req.vtx[i][EFF_W-1:0]});
        end
    end

    // Operand selection and sum
    always_comb begin
        nop  = fnvi_pkg::node_op(i_req.scheme, i_req.k);
        va   = v[nop.a];
        vb   = v[nop.b];
        vc   = v[nop.c];
        vd   = v[nop.d];
        all8 = v[0] + v[1] + v[2] + v[3] + v[4] + v[5] + v[6] + v[7];
        n_stage.valid = i_req.valid;
        n_stage.idx   = i_req.k;
        n_stage.last  = i_req.last;
        n_stage.rem   = 4'd0;
        n_stage.dsel  = fnvi_pkg::DIV_NONE;
        sum           = va;
        case (nop.op)
            fnvi_pkg::OP_COPY:   sum = va;
            fnvi_pkg::OP_HALF:   sum = (va + vb) >>> 1;
            fnvi_pkg::OP_QUART:  sum = (va + vb + vc + vd) >>> 2;
            fnvi_pkg::OP_EIGHTH: sum = all8 >>> 3;
            fnvi_pkg::OP_THIRD: begin
                sum          = (va <<< 1) + vb;
                n_stage.dsel = fnvi_pkg::DIV_3;
            end
            fnvi_pkg::OP_NINTH: begin
                sum          = (va <<< 1) - vb + (vc <<< 3);
                n_stage.dsel = fnvi_pkg::DIV_9;
            end
            default:             sum = va;
        endcase
        // divisions work on the magnitude and truncate toward zero
        n_stage.neg  = (n_stage.dsel != fnvi_pkg::DIV_NONE) && sum[WW-1];
        n_stage.word = n_stage.neg ? WW'(-sum) : WW'(sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
        r_stage.idx  <= n_stage.idx;
        r_stage.last <= n_stage.last;
        r_stage.dsel <= n_stage.dsel;
        r_stage.neg  <= n_stage.neg;
        r_stage.rem  <= n_stage.rem;
        r_stage.word <= n_stage.word;
    end

    assign o_stage = r_stage;

endmodule

// ----- src/fnvi_div_stage.sv -----
// One stage of the constant divider (by 3 or 9): three hex digits of long division.
// Depends on fnvi_pkg.
module fnvi_div_stage #(
    parameter int STAGE = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fnvi_pkg::t_dpipe i_stage,
    output fnvi_pkg::t_dpipe o_stage
);

    localparam int TOP_DIG = fnvi_pkg::NDIG - 1 - STAGE * fnvi_pkg::DIG_PER_STAGE;

    fnvi_pkg::t_dpipe n_stage;
    fnvi_pkg::t_dpipe r_stage;
    logic [3:0]       divisor;
    logic [7:0]       step;

    // Digits from the top down; each quotient digit replaces its dividend digit
    always_comb begin
        n_stage = i_stage;
        divisor = (i_stage.dsel == fnvi_pkg::DIV_9) ? 4'd9 : 4'd3;
        step    = 8'd0;
        if (i_stage.dsel != fnvi_pkg::DIV_NONE) begin
            for (int j = 0; j < fnvi_pkg::DIG_PER_STAGE; j++) begin
                step = fnvi_pkg::div_digit({n_stage.rem, n_stage.word[(TOP_DIG - j) * 4 +: 4]},
                                           divisor);
                n_stage.word[(TOP_DIG - j) * 4 +: 4] = step[7:4];
                n_stage.rem                          = step[3:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
        r_stage.idx  <= n_stage.idx;
        r_stage.last <= n_stage.last;
        r_stage.dsel <= n_stage.dsel;
        r_stage.neg  <= n_stage.neg;
        r_stage.rem  <= n_stage.rem;
        r_stage.word <= n_stage.word;
    end

    assign o_stage = r_stage;

endmodule

// ----- src/fe_nodal_value_interpolator.sv -----
// Top level of the nodal value interpolator: sequencer, node arithmetic, divider, output.
// Depends on fnvi_pkg, fnvi_seq, fnvi_node_calc and fnvi_div_stage.
//
// Usage
//   Input: an item (element kind, order, copy count, eight vertex values) is taken
//   at a rising edge where start is high and busy is low. One item is being emitted
//   while a second may wait in a holding register; busy is high while that holding
//   register is full.
//   Output: each nodal value is shown on o_result for one cycle with o_strobe high,
//   in node order, last_node marking the final node of the item. An item with no
//   nodes (pass-through with a copy count of zero) is taken and gives nothing.
//   Path: each node passes in order through the sequencer, the sum stage, three
//   divider stages and the output register.
//   Throughput: one node per cycle; an item of N nodes gives N results (27 for the
//   largest element), and items follow each other without gaps.
//   The node rate is set by the single node counter in the sequencer.
//   Reset (synchronous, active low) empties both item registers and the pipeline.
//   The receiver cannot stall: results leave whenever o_strobe is high.
module fe_nodal_value_interpolator #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  fnvi_pkg::t_in_item   i_item,
    output logic                 o_strobe,
    output fnvi_pkg::t_out_item  o_result
);

    localparam int EFF_W = (VALUE_WIDTH < fnvi_pkg::VTX_W) ? VALUE_WIDTH : fnvi_pkg::VTX_W;
    localparam int WW    = fnvi_pkg::WORD_W;
    localparam logic signed [WW-1:0] SAT_HI = WW'((64'sd1 <<< (EFF_W - 1)) - 64'sd1);
    localparam logic signed [WW-1:0] SAT_LO = -SAT_HI - WW'(1);

    fnvi_pkg::t_node_req  req;
    fnvi_pkg::t_dpipe     pipe [fnvi_pkg::DIV_STAGES + 1];
    fnvi_pkg::t_dpipe     tail;
    logic signed [WW-1:0] value;
    logic signed [WW-1:0] clipped;
    logic                 r_strobe;
    fnvi_pkg::t_out_item  r_result, n_result;

    fnvi_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_req   (req)
    );

    fnvi_node_calc #(
        .EFF_W (EFF_W)
    ) u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_stage (pipe[0])
    );

    // Divider pipeline
    for (genvar s = 0; s < fnvi_pkg::DIV_STAGES; s++) begin : g_div
        fnvi_div_stage #(
            .STAGE (s)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (pipe[s]),
            .o_stage (pipe[s+1])
        );
    end

    assign tail = pipe[fnvi_pkg::DIV_STAGES];

    // Restore sign and saturate to the value width
    always_comb begin
        value = $signed(tail.word);
        if (tail.neg) value = -$signed(tail.word);
        if (value > SAT_HI) begin
            clipped = SAT_HI;
        end else if (value < SAT_LO) begin
            clipped = SAT_LO;
        end else begin
            clipped = value;
        end
        n_result.node_index = tail.idx;
        n_result.node_value = clipped[fnvi_pkg::VTX_W-1:0];
        n_result.last_node  = tail.last;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= tail.valid;
        end
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ----- src/fnvi_checker.sv -----
// Port-level checks for the nodal value interpolator, bound to the top level.
// Depends on fnvi_pkg and fe_nodal_value_interpolator.
module fnvi_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input fnvi_pkg::t_in_item  i_item,
    input logic                o_strobe,
    input fnvi_pkg::t_out_item o_result
);

    // Nodes of one item leave back to back with rising indices
    a_next_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last_node |=>
            o_strobe && o_result.node_index == $past(o_result.node_index) + 5'd1)
        else $error("node sequence broken within an item");

    // A new item starts at node zero
    a_first_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last_node |=> !o_strobe || o_result.node_index == 5'd0)
        else $error("item does not start at node zero");

    // No element has more than 27 nodes
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_result.node_index <= 5'd26)
        else $error("node index out of range");

    // Reset empties the block
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_strobe)
        else $error("block not empty after reset");

    // The holding register only fills from an offered item
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an item offered");

endmodule

bind fe_nodal_value_interpolator fnvi_checker u_fnvi_checker (.*);
